>>> hdl/osvl_pkg.sv
// ----------------------------------------------------------------------------
// osvl_pkg: shared definitions for the oversampled state-variable lowpass
// Coefficient formats, register indexes and sequencer state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package osvl_pkg;

  // Coefficient formats: f is Q0.24, damping is Q2.22
  localparam int COEF_W  = 24;
  localparam int F_SHIFT = 24;
  localparam int D_SHIFT = 22;

  // Rounding of the low partial product (24 x 24 bits plus carry)
  localparam int RNDW  = 2 * COEF_W + 1;
  localparam int PARTW = RNDW - D_SHIFT;

  // Configuration port
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CNT_W      = 7;

  localparam logic [CNT_W-1:0]  MAX_OVERSAMPLE   = 7'd64;
  localparam logic [CNT_W-1:0]  RESET_OVERSAMPLE = 7'd60;
  localparam logic [COEF_W-1:0] RESET_DAMPING    = 24'd4194304;
  localparam logic [COEF_W-1:0] RESET_COEF_F     = 24'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_F     = 2'd0,
    CFG_DAMPING    = 2'd1,
    CFG_OVERSAMPLE = 2'd2
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS,
    ST_LO,
    ST_HI,
    ST_FIN,
    ST_HP,
    ST_BP,
    ST_LP,
    ST_DONE
  } state_e;

  // Which product the shared multiplier is working on
  typedef enum logic [1:0] {
    PH_DAMP,
    PH_HPF,
    PH_LPF
  } phase_e;

endpackage : osvl_pkg

`default_nettype wire

>>> hdl/oversampled_state_variable_lowpass.sv
// ----------------------------------------------------------------------------
// oversampled_state_variable_lowpass: Chamberlin state-variable lowpass
// Runs oversample_count filter iterations per input sample on one shared
// multiplier and returns the saturated lowpass tap when asked.
// ----------------------------------------------------------------------------
// Each accepted sample keeps the block busy until all of its iterations are
// done, where oversample_count is clamped to 64 (the default is 60). The work
// is set by the single 24-bit-limb multiplier: each of the
// three products of an iteration (damping, f times highpass, f times
// bandpass) goes through an absolute-value step, two limb multiplies and a
// join-and-sign step, plus one add step each for highpass, bandpass and lowpass. A result
// beat is produced only when emit_result is set; it sits in an output
// register, so the next sample can be accepted while it waits.
`default_nettype none

module oversampled_state_variable_lowpass #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int STATE_WIDTH  = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Configuration writes
  input  wire                                 cfg_we_i,
  input  wire [osvl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire [osvl_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Sample channel
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire signed [SAMPLE_WIDTH-1:0]       sample_in_i,
  input  wire                                 restart_i,
  input  wire                                 emit_result_i,
  // Result channel
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      lowpass_out_o,
  output logic                                clipped_o
);

  import osvl_pkg::*;

  // Datapath widths
  localparam int HPW  = STATE_WIDTH + 4;               // highpass / operand
  localparam int HIW  = HPW - COEF_W;                  // upper limb
  localparam int LW   = (HIW > COEF_W) ? HIW : COEF_W; // multiplier operand
  localparam int PW   = LW + COEF_W;                   // product
  localparam int MRW  = PW + 3;                        // rounded magnitude
  localparam int RESW = STATE_WIDTH + 8;               // signed product
  localparam int SUMW = RESW + 1;                      // accumulator add
  localparam int EXTW = ((STATE_WIDTH > SAMPLE_WIDTH) ? STATE_WIDTH : SAMPLE_WIDTH) + 1;

  // Configuration registers
  logic [COEF_W-1:0] coef_f_q;
  logic [COEF_W-1:0] damping_q;
  logic [CNT_W-1:0]  os_count_q;

  // Sequencer and datapath registers
  state_e                   state_q, state_d;
  phase_e                   phase_q;
  logic [CNT_W-1:0]         iter_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic                     emit_q;
  logic                     clip_q;
  logic signed [STATE_WIDTH-1:0]  bp_q;
  logic signed [STATE_WIDTH-1:0]  lp_q;
  logic signed [HPW-1:0]    op_q;
  logic [HPW-1:0]           mag_q;
  logic                     neg_q;
  logic [PW-1:0]            prod_q;
  logic [PARTW-1:0]         part_q;
  logic signed [RESW-1:0]   res_q;

  // Output register
  logic                     out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] lowpass_out_q;
  logic                     clipped_q;

  // Control from the output decoder
  logic in_accept;
  logic load_out;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_f_q   <= RESET_COEF_F;
      damping_q  <= RESET_DAMPING;
      os_count_q <= RESET_OVERSAMPLE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COEF_F:     coef_f_q   <= cfg_data_i[COEF_W-1:0];
        CFG_DAMPING:    damping_q  <= cfg_data_i[COEF_W-1:0];
        CFG_OVERSAMPLE: os_count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (os_count_q == '0) ? ST_DONE : ST_ABS;
        end
      end
      ST_ABS: state_d = ST_LO;
      ST_LO:  state_d = ST_HI;
      ST_HI:  state_d = ST_FIN;
      ST_FIN: begin
        case (phase_q)
          PH_DAMP: state_d = ST_HP;
          PH_HPF:  state_d = ST_BP;
          default: state_d = ST_LP;
        endcase
      end
      ST_HP:  state_d = ST_ABS;
      ST_BP:  state_d = ST_ABS;
      ST_LP:  state_d = (iter_q == CNT_W'(1)) ? ST_DONE : ST_ABS;
      ST_DONE: begin
        if (!emit_q || !out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake decode
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    in_accept  = in_ready_o && in_valid_i;
    load_out   = (state_q == ST_DONE) && emit_q && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: one limb of the magnitude times a coefficient
  // ---------------------------------------------------------------------------
  logic              sh22;
  logic [LW-1:0]     mul_a;
  logic [COEF_W-1:0] mul_b;
  logic [PW-1:0]     mul_p;

  assign sh22  = (phase_q == PH_DAMP);
  assign mul_a = (state_q == ST_LO) ? LW'(mag_q[COEF_W-1:0]) : LW'(mag_q[HPW-1:COEF_W]);
  assign mul_b = sh22 ? damping_q : coef_f_q;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Round the low partial product, ties away from zero on the magnitude
  logic [RNDW-1:0]  rnd_sum;
  logic [PARTW-1:0] part_d;

  always_comb begin
    rnd_sum = RNDW'(prod_q[2*COEF_W-1:0])
            + (sh22 ? (RNDW'(1) << (D_SHIFT - 1)) : (RNDW'(1) << (F_SHIFT - 1)));
    part_d  = sh22 ? PARTW'(rnd_sum[RNDW-1:D_SHIFT]) : PARTW'(rnd_sum[RNDW-1:F_SHIFT]);
  end

  // Join high partial product and rounded low part, then restore the sign
  logic [MRW-1:0]         mag_full;
  logic signed [RESW-1:0] mag_s;
  logic signed [RESW-1:0] res_d;

  always_comb begin
    mag_full = (sh22 ? (MRW'(prod_q) << (F_SHIFT - D_SHIFT)) : MRW'(prod_q))
             + MRW'(part_q);
    mag_s    = mag_full[RESW-1:0];
    res_d    = neg_q ? -mag_s : mag_s;
  end

  // ---------------------------------------------------------------------------
  // Highpass and saturating accumulator updates
  // ---------------------------------------------------------------------------
  logic signed [RESW-1:0] hp_full;
  logic signed [SUMW-1:0] bp_sum;
  logic signed [SUMW-1:0] lp_sum;
  logic                   bp_ok;
  logic                   lp_ok;
  logic signed [STATE_WIDTH-1:0] bp_sat;
  logic signed [STATE_WIDTH-1:0] lp_sat;

  always_comb begin
    hp_full = RESW'(x_q) - RESW'(lp_q) - res_q;
    bp_sum  = SUMW'(bp_q) + SUMW'(res_q);
    lp_sum  = SUMW'(lp_q) + SUMW'(res_q);
    bp_ok   = (&bp_sum[SUMW-1:STATE_WIDTH-1]) | ~(|bp_sum[SUMW-1:STATE_WIDTH-1]);
    lp_ok   = (&lp_sum[SUMW-1:STATE_WIDTH-1]) | ~(|lp_sum[SUMW-1:STATE_WIDTH-1]);
    bp_sat  = bp_ok ? bp_sum[STATE_WIDTH-1:0]
                    : {bp_sum[SUMW-1], {(STATE_WIDTH-1){~bp_sum[SUMW-1]}}};
    lp_sat  = lp_ok ? lp_sum[STATE_WIDTH-1:0]
                    : {lp_sum[SUMW-1], {(STATE_WIDTH-1){~lp_sum[SUMW-1]}}};
  end

  // Output saturation of the lowpass tap to sample width
  logic signed [EXTW-1:0]         lp_ext;
  logic                           out_ok;
  logic signed [SAMPLE_WIDTH-1:0] out_sat;

  always_comb begin
    lp_ext  = EXTW'(lp_q);
    out_ok  = (&lp_ext[EXTW-1:SAMPLE_WIDTH-1]) | ~(|lp_ext[EXTW-1:SAMPLE_WIDTH-1]);
    out_sat = out_ok ? lp_ext[SAMPLE_WIDTH-1:0]
                     : {lp_ext[EXTW-1], {(SAMPLE_WIDTH-1){~lp_ext[EXTW-1]}}};
  end

  // ---------------------------------------------------------------------------
  // Control registers of the datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DAMP;
      iter_q  <= '0;
      emit_q  <= 1'b0;
      clip_q  <= 1'b0;
      bp_q    <= '0;
      lp_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            phase_q <= PH_DAMP;
            iter_q  <= (os_count_q > MAX_OVERSAMPLE) ? MAX_OVERSAMPLE : os_count_q;
            emit_q  <= emit_result_i;
            clip_q  <= 1'b0;
            if (restart_i) begin
              bp_q <= '0;
              lp_q <= '0;
            end
          end
        end
        ST_HP: phase_q <= PH_HPF;
        ST_BP: begin
          phase_q <= PH_LPF;
          bp_q    <= bp_sat;
          if (!bp_ok) begin
            clip_q <= 1'b1;
          end
        end
        ST_LP: begin
          phase_q <= PH_DAMP;
          iter_q  <= iter_q - CNT_W'(1);
          lp_q    <= lp_sat;
          if (!lp_ok) begin
            clip_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers of the datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q  <= sample_in_i;
        op_q <= restart_i ? '0 : HPW'(bp_q);
      end
      ST_ABS: begin
        mag_q <= op_q[HPW-1] ? -op_q : op_q;
        neg_q <= op_q[HPW-1];
      end
      ST_LO: prod_q <= mul_p;
      ST_HI: begin
        part_q <= part_d;
        prod_q <= mul_p;
      end
      ST_FIN: res_q <= res_d;
      ST_HP:  op_q  <= hp_full[HPW-1:0];
      ST_BP:  op_q  <= HPW'(bp_sat);
      ST_LP:  op_q  <= HPW'(bp_q);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register: hold the beat until taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      lowpass_out_q <= out_sat;
      clipped_q     <= clip_q | ~out_ok;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign lowpass_out_o = lowpass_out_q;
  assign clipped_o     = clipped_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sample accepted while the previous one is still running");

  a_restart_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && restart_i |=> (bp_q == '0) && (lp_q == '0))
    else $error("restart did not clear the filter state");

  a_iter_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> iter_q <= MAX_OVERSAMPLE)
    else $error("iteration count beyond the limit");

  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result beat raised outside the completion step");

endmodule : oversampled_state_variable_lowpass

`default_nettype wire

>>> sim/tb_oversampled_state_variable_lowpass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oversampled_state_variable_lowpass: self-checking bench for the lowpass
// Feeds samples on the valid/ready channel and runs a cycle-free model of
// the filter on every accepted beat. Each result beat is compared field by
// field with the oldest predicted beat. The run walks through directed
// corner settings and then random coefficient and oversample settings,
// under random sender and receiver stalls in most phases.
// ----------------------------------------------------------------------------

module tb_oversampled_state_variable_lowpass;
  import osvl_pkg::*;

  localparam int SAMPLE_W    = 24;
  localparam int STATE_W     = 32;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [COEF_W-1:0]          COEF_MAX   = {COEF_W{1'b1}};
  localparam logic [COEF_W-1:0]          DAMP_ONE   = 24'd4194304;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
    logic                       emit;
  } sample_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lowpass;
    logic                       clipped;
  } lp_result_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  cfg_idx_e                   cfg_idx_i     = CFG_COEF_F;
  logic [CFG_DATA_W-1:0]      cfg_data_i    = '0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_in_i   = '0;
  logic                       restart_i     = 1'b0;
  logic                       emit_result_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i   = 1'b0;
  logic signed [SAMPLE_W-1:0] lowpass_out_o;
  logic                       clipped_o;

  // Model copy of the registers and filter state
  logic [COEF_W-1:0]          cutoff_coef = RESET_COEF_F;
  logic [COEF_W-1:0]          damp_coef   = RESET_DAMPING;
  logic [CNT_W-1:0]           iter_cnt    = RESET_OVERSAMPLE;
  logic signed [STATE_W-1:0]  bp_acc      = '0;
  logic signed [STATE_W-1:0]  lp_acc      = '0;

  sample_beat_t sample_feed_q[$];
  lp_result_t   lowpass_expect_q[$];
  sample_beat_t next_beat;
  lp_result_t   want;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           send_hold     = 1'b0;
  int           fail_cnt      = 0;
  int unsigned  cycle_cnt     = 0;

  oversampled_state_variable_lowpass #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .STATE_WIDTH (STATE_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .restart_i    (restart_i),
    .emit_result_i(emit_result_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .lowpass_out_o(lowpass_out_o),
    .clipped_o    (clipped_o)
  );

  always #5 clk_i = ~clk_i;

  // Multiply by an unsigned coefficient, shift right, round half away from zero
  function automatic longint scale_round(longint a, logic [COEF_W-1:0] coef, int sh);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = (a < 0) ? -a : a;
    prod = (mag * coef + (64'd1 << (sh - 1))) >> sh;
    return (a < 0) ? -$signed(prod) : $signed(prod);
  endfunction

  function automatic longint clamp(longint v, int w);
    longint top;
    top = 1;
    top = (top << (w - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  // Run the oversampled iterations for one sample and queue its result
  task automatic advance_filter(input logic signed [SAMPLE_W-1:0] x_in,
                                input logic clear_state, input logic emit);
    longint     x, hp, bp, lp, sum;
    int         n, i;
    bit         clip;
    lp_result_t res;
    x    = longint'(x_in);
    clip = 1'b0;
    if (clear_state) begin
      bp_acc = '0;
      lp_acc = '0;
    end
    n  = int'((iter_cnt > MAX_OVERSAMPLE) ? MAX_OVERSAMPLE : iter_cnt);
    bp = longint'(bp_acc);
    lp = longint'(lp_acc);
    for (i = 0; i < n; i++) begin
      hp   = x - lp - scale_round(bp, damp_coef, D_SHIFT);
      sum  = bp + scale_round(hp, cutoff_coef, F_SHIFT);
      bp   = clamp(sum, STATE_W);
      clip = clip | (bp != sum);
      sum  = lp + scale_round(bp, cutoff_coef, F_SHIFT);
      lp   = clamp(sum, STATE_W);
      clip = clip | (lp != sum);
    end
    bp_acc = bp[STATE_W-1:0];
    lp_acc = lp[STATE_W-1:0];
    if (emit) begin
      sum         = clamp(lp, SAMPLE_W);
      clip        = clip | (sum != lp);
      res.lowpass = sum[SAMPLE_W-1:0];
      res.clipped = clip;
      lowpass_expect_q.push_back(res);
    end
  endtask

  // Sample driver: predict on each accepted beat, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      sample_in_i   <= '0;
      restart_i     <= 1'b0;
      emit_result_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        advance_filter(sample_in_i, restart_i, emit_result_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (sample_feed_q.size() != 0 && !send_hold &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          next_beat      = sample_feed_q.pop_front();
          sample_in_i   <= next_beat.sample;
          restart_i     <= next_beat.restart;
          emit_result_i <= next_beat.emit;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i    <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (lowpass_expect_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result lowpass %0d clipped %0b",
                   $time, lowpass_out_o, clipped_o);
        end else begin
          want = lowpass_expect_q.pop_front();
          if (lowpass_out_o !== want.lowpass) begin
            fail_cnt++;
            $display("%0t: lowpass expected %0d actual %0d",
                     $time, want.lowpass, lowpass_out_o);
          end
          if (clipped_o !== want.clipped) begin
            fail_cnt++;
            $display("%0t: clipped expected %0b actual %0b",
                     $time, want.clipped, clipped_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic feed(input logic signed [SAMPLE_W-1:0] s, input logic r, input logic e);
    sample_beat_t beat;
    beat.sample  = s;
    beat.restart = r;
    beat.emit    = e;
    sample_feed_q.push_back(beat);
  endtask

  // Wait for all beats to go through, then for one full sample's worth of cycles
  task automatic drain();
    int n;
    while (sample_feed_q.size() != 0 || in_valid_i || lowpass_expect_q.size() != 0)
      @(negedge clk_i);
    n = int'((iter_cnt > MAX_OVERSAMPLE) ? MAX_OVERSAMPLE : iter_cnt);
    repeat (15 * n + 10) @(negedge clk_i);
  endtask

  task automatic load_config(input logic [COEF_W-1:0] f, input logic [COEF_W-1:0] d,
                             input logic [CNT_W-1:0] n);
    logic [CFG_DATA_W-1:0] word;
    word            = CFG_DATA_W'($urandom());
    word[CNT_W-1:0] = n;
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_COEF_F;
    cfg_data_i <= f;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DAMPING;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_OVERSAMPLE;
    cfg_data_i <= word;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cutoff_coef = f;
    damp_coef   = d;
    iter_cnt    = n;
    @(negedge clk_i);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 14; recv_idle_pct = 67; end
      1: begin send_idle_pct = 67; recv_idle_pct = 14; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int t;
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: begin
        t = $urandom_range(0, 255);
        t = t - 128;
        return t[SAMPLE_W-1:0];
      end
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Mostly restart-led runs of samples, some with a priming pass; a little noise
  task automatic queue_random(input int total);
    int                         left, run, i;
    logic signed [SAMPLE_W-1:0] s;
    logic                       r;
    left = total;
    s    = '0;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        feed(SAMPLE_W'($urandom()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        left--;
      end else begin
        run = $urandom_range(2, 12);
        for (i = 0; i < run && left > 0; i++) begin
          if (i == 0 || $urandom_range(0, 1)) s = pick_sample();
          r = (i == 0) && ($urandom_range(0, 3) != 0);
          if ($urandom_range(0, 4) == 0 && left > 1) begin
            feed(s, r, 1'b0);
            r = 1'b0;
            left--;
          end
          feed(s, r, 1'b1);
          left--;
        end
      end
    end
  endtask

  initial begin : stimulus
    int                ph, n_items;
    logic [CNT_W-1:0]  n_iter;
    logic [COEF_W-1:0] f, d;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_idle(0);

    // Reset settings: zero cutoff keeps the output at zero
    feed(SAMPLE_MAX, 1'b1, 1'b1);
    feed(SAMPLE_MIN, 1'b0, 1'b0);
    feed('0, 1'b0, 1'b1);
    drain();

    // Moderate cutoff: priming passes, extremes, mid-stream restart
    load_config(24'h400000, DAMP_ONE, 7'd4);
    feed(SAMPLE_MAX, 1'b1, 1'b0);
    feed(SAMPLE_MAX, 1'b0, 1'b0);
    feed(SAMPLE_MAX, 1'b0, 1'b1);
    feed(SAMPLE_MIN, 1'b0, 1'b1);
    feed(SAMPLE_MIN, 1'b0, 1'b1);
    feed('0, 1'b0, 1'b1);
    feed(24'sd12345, 1'b1, 1'b1);
    feed(-24'sd1, 1'b0, 1'b1);
    drain();

    // Full cutoff, no damping, maximum count: drive the state into saturation
    load_config(COEF_MAX, '0, MAX_OVERSAMPLE);
    feed(SAMPLE_MAX, 1'b1, 1'b1);
    feed(SAMPLE_MAX, 1'b0, 1'b1);
    feed(SAMPLE_MIN, 1'b0, 1'b1);
    feed(SAMPLE_MAX, 1'b0, 1'b1);
    drain();

    // Count above the maximum is held at the maximum
    load_config(COEF_MAX, COEF_MAX, 7'd127);
    feed(SAMPLE_MIN, 1'b1, 1'b1);
    feed(SAMPLE_MAX, 1'b0, 1'b1);
    feed(SAMPLE_MIN, 1'b0, 1'b1);
    drain();

    // Zero count: state holds, restart still clears it
    load_config(24'h123456, DAMP_ONE, 7'd0);
    feed(SAMPLE_MAX, 1'b1, 1'b1);
    feed(SAMPLE_MAX, 1'b0, 1'b1);
    feed(SAMPLE_MIN, 1'b0, 1'b0);
    feed(24'sd1, 1'b0, 1'b1);
    drain();

    // Random settings, mostly short counts
    for (ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin n_iter = 7'd3;   n_items = 230; end
        1: begin n_iter = 7'd1;   n_items = 230; end
        2: begin n_iter = 7'd8;   n_items = 200; end
        3: begin n_iter = 7'd64;  n_items = 30;  end
        4: begin n_iter = 7'd0;   n_items = 150; end
        5: begin n_iter = 7'd5;   n_items = 230; end
        6: begin n_iter = 7'd100; n_items = 20;  end
        7: begin n_iter = 7'd2;   n_items = 230; end
        default: begin n_iter = 7'd16; n_items = 200; end
      endcase
      case ($urandom_range(0, 3))
        0: f = COEF_W'($urandom());
        1: f = COEF_W'($urandom_range(0, 24'h1FFFFF));
        2: f = COEF_MAX;
        default: f = COEF_W'($urandom_range(24'h100000, 24'h800000));
      endcase
      case ($urandom_range(0, 3))
        0: d = '0;
        1: d = COEF_MAX;
        2: d = DAMP_ONE;
        default: d = COEF_W'($urandom());
      endcase
      set_idle(ph / 3);
      load_config(f, d, n_iter);
      queue_random(n_items);
      // Hold the sender mid-phase until every pending result is back
      if (ph == 1) begin
        while (sample_feed_q.size() > n_items / 2) @(negedge clk_i);
        send_hold = 1'b1;
        while (in_valid_i || lowpass_expect_q.size() != 0) @(negedge clk_i);
        send_hold = 1'b0;
      end
      drain();
    end

    if (fail_cnt == 0 && lowpass_expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/osvl_pkg.sv
hdl/oversampled_state_variable_lowpass.sv
sim/tb_oversampled_state_variable_lowpass.sv
